[design/tccw_pkg.sv]
package tccw_pkg;

	localparam int COLUMNS_DEF   = 80;
	localparam int ROWS_DEF      = 25;
	localparam int TAB_WIDTH_DEF = 4;

	localparam int ROW_W       = 5;
	localparam int COL_W       = 7;
	localparam int CHAR_W      = 8;
	localparam int CELL_W      = 16;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 32;

	localparam logic [7:0]  CODE_NL    = 8'd10;
	localparam logic [7:0]  CODE_CR    = 8'd13;
	localparam logic [7:0]  CODE_TAB   = 8'd9;
	localparam logic [7:0]  CODE_BS    = 8'd8;
	localparam logic [7:0]  BLANK_CHAR = 8'h20;
	localparam logic [7:0]  ATTR_RESET = 8'h07;
	localparam logic [15:0] RESET_CELL = 16'h0720;

	typedef enum logic [1:0] {
		MODE_PUT   = 2'd0,
		MODE_SET   = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_COPY,
		ST_BLANK,
		ST_CLEAR,
		ST_DONE
	} state_t;

endpackage

[design/text_console_cell_writer_core.sv]
// Steps, accept to result: put, set cursor and control codes take an execute step; a cell
// read adds the registered memory read; a put that scrolls adds a row copy (through the
// cell memory's read and write ports, one cell a cycle) and then blanks the bottom row.
// Clear screen: an execute step, then a pass over every cell. A full result register adds
// its wait. One item at a time: the next accept comes in the cycle after the result is
// registered. After arst_n deasserts, a clearing pass fills the store with 0x0720.
module text_console_cell_writer_core #(
	parameter int COLUMNS   = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS      = tccw_pkg::ROWS_DEF,
	parameter int TAB_WIDTH = tccw_pkg::TAB_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [7:0]                         cfg_data,   // text_attr
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// mode[1:0], char_code[9:2], set_row[14:10], set_col[21:15], zero[23:22]
	input  logic [tccw_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// cursor_row[4:0], cursor_col[11:5], scrolled[12], cell_char[20:13],
	// cell_attr[28:21], zero[31:29]
	output logic [tccw_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	localparam int CELLS     = ROWS * COLUMNS;
	localparam int AW        = $clog2(CELLS);
	localparam int TAB_RECIP = (4096 + TAB_WIDTH - 1) / TAB_WIDTH;
	localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
	localparam logic [AW-1:0] COPY_END   = AW'(CELLS - COLUMNS);
	localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
	localparam logic [5:0]    ROWS_L     = 6'(ROWS);
	localparam logic [9:0]    COLS_L     = 10'(COLUMNS);
	localparam logic [4:0]    LAST_ROW   = 5'(ROWS - 1);
	localparam logic [6:0]    LAST_COL   = 7'(COLUMNS - 1);

	tccw_pkg::state_t state_q, state_d;
	tccw_pkg::mode_t  mode_q;

	logic [AW-1:0] cnt_q;
	logic [7:0]    char_q;
	logic [4:0]    srow_q;
	logic [6:0]    scol_q;
	logic [4:0]    row_q;
	logic [6:0]    col_q;
	logic [7:0]    attr_q;
	logic          scr_q;
	logic          m_tvalid_q;
	logic [tccw_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	logic [15:0]   mem [CELLS];
	logic [15:0]   rd_q;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [15:0]   wr_data;

	logic          in_acc;
	logic          out_free;
	logic          rd_ok;
	logic [18:0]   tab_prod;
	logic [9:0]    tab_next;
	logic [5:0]    row_b;
	logic [9:0]    col_b;
	logic [5:0]    row_w;
	logic [9:0]    col_w;
	logic [4:0]    row_d;
	logic [6:0]    col_d;
	logic          scroll;
	logic          put_wr;
	logic [4:0]    put_row;
	logic [6:0]    put_col;
	logic [7:0]    put_char;
	logic          direct;
	logic          ld_out;
	logic [4:0]    out_row;
	logic [6:0]    out_col;
	logic          out_scr;
	logic [7:0]    out_ch;
	logic [7:0]    out_at;
	logic [15:0]   blank;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == tccw_pkg::ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign out_free  = !m_tvalid_q || m_tready;
	assign blank     = {attr_q, tccw_pkg::BLANK_CHAR};
	assign rd_ok     = ({1'b0, srow_q} < ROWS_L) && ({3'b0, scol_q} < COLS_L);

	assign tab_prod = 19'(col_q) * 19'(TAB_RECIP);
	assign tab_next = (10'(tab_prod[18:12]) + 10'd1) * 10'(TAB_WIDTH);

	// cursor arithmetic for put character
	always_comb begin
		row_b    = {1'b0, row_q};
		col_b    = 10'(col_q);
		put_wr   = 1'b0;
		put_row  = row_q;
		put_col  = col_q;
		put_char = char_q;
		case (char_q)
			tccw_pkg::CODE_NL: begin
				col_b = '0;
				row_b = row_b + 6'd1;
			end
			tccw_pkg::CODE_CR: begin
				col_b = '0;
			end
			tccw_pkg::CODE_TAB: begin
				col_b = tab_next;
			end
			tccw_pkg::CODE_BS: begin
				if (col_q != '0) begin
					col_b = col_b - 10'd1;
				end else if (row_q != '0) begin
					row_b = row_b - 6'd1;
					col_b = 10'(LAST_COL);
				end
				put_wr   = 1'b1;
				put_row  = row_b[4:0];
				put_col  = col_b[6:0];
				put_char = tccw_pkg::BLANK_CHAR;
			end
			default: begin
				put_wr = 1'b1;
				col_b  = col_b + 10'd1;
			end
		endcase
		row_w = row_b;
		col_w = col_b;
		if (col_b >= COLS_L) begin
			col_w = '0;
			row_w = row_b + 6'd1;
		end
		scroll = 1'b0;
		if (row_w >= ROWS_L) begin
			scroll = 1'b1;
			row_w  = {1'b0, LAST_ROW};
		end
	end

	// next cursor at the end of the execute step
	always_comb begin
		row_d = row_q;
		col_d = col_q;
		case (mode_q)
			tccw_pkg::MODE_PUT: begin
				row_d = row_w[4:0];
				col_d = col_w[6:0];
			end
			tccw_pkg::MODE_SET: begin
				if ({1'b0, srow_q} < ROWS_L) row_d = srow_q;
				if ({3'b0, scol_q} < COLS_L) col_d = scol_q;
			end
			tccw_pkg::MODE_CLEAR: begin
				row_d = '0;
				col_d = '0;
			end
			default: begin
				row_d = row_q;
				col_d = col_q;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tccw_pkg::ST_INIT: begin
				if (cnt_q == LAST_CELL) state_d = tccw_pkg::ST_IDLE;
			end
			tccw_pkg::ST_IDLE: begin
				if (in_acc) state_d = tccw_pkg::ST_EXEC;
			end
			tccw_pkg::ST_EXEC: begin
				if (mode_q == tccw_pkg::MODE_CLEAR) begin
					state_d = tccw_pkg::ST_CLEAR;
				end else if (mode_q == tccw_pkg::MODE_PUT && scroll) begin
					state_d = tccw_pkg::ST_COPY;
				end else if (direct) begin
					state_d = tccw_pkg::ST_IDLE;
				end else begin
					state_d = tccw_pkg::ST_DONE;
				end
			end
			tccw_pkg::ST_COPY: begin
				if (cnt_q == COPY_END) state_d = tccw_pkg::ST_BLANK;
			end
			tccw_pkg::ST_BLANK, tccw_pkg::ST_CLEAR: begin
				if (cnt_q == LAST_CELL) state_d = tccw_pkg::ST_DONE;
			end
			tccw_pkg::ST_DONE: begin
				if (out_free) state_d = tccw_pkg::ST_IDLE;
			end
			default: state_d = tccw_pkg::ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q;
		wr_data = blank;
		rd_addr = AW'(12'(srow_q) * 12'(COLUMNS) + 12'(scol_q));
		direct  = 1'b0;
		ld_out  = 1'b0;
		out_row = row_q;
		out_col = col_q;
		out_scr = scr_q;
		out_ch  = '0;
		out_at  = '0;
		case (state_q)
			tccw_pkg::ST_INIT: begin
				wr_en   = 1'b1;
				wr_data = tccw_pkg::RESET_CELL;
			end
			tccw_pkg::ST_EXEC: begin
				wr_en   = (mode_q == tccw_pkg::MODE_PUT) && put_wr;
				wr_addr = AW'(12'(put_row) * 12'(COLUMNS) + 12'(put_col));
				wr_data = {attr_q, put_char};
				direct  = out_free && (mode_q == tccw_pkg::MODE_SET ||
					(mode_q == tccw_pkg::MODE_PUT && !scroll));
				ld_out  = direct;
				out_row = row_d;
				out_col = col_d;
				out_scr = 1'b0;
			end
			tccw_pkg::ST_COPY: begin
				rd_addr = cnt_q + COLS_A;
				wr_en   = (cnt_q != '0);
				wr_addr = cnt_q - AW'(1);
				wr_data = rd_q;
			end
			tccw_pkg::ST_BLANK, tccw_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
			end
			tccw_pkg::ST_DONE: begin
				ld_out = out_free;
				if (mode_q == tccw_pkg::MODE_READ && rd_ok) begin
					out_ch = rd_q[7:0];
					out_at = rd_q[15:8];
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tccw_pkg::ST_INIT;
			cnt_q      <= '0;
			row_q      <= '0;
			col_q      <= '0;
			attr_q     <= tccw_pkg::ATTR_RESET;
			scr_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				attr_q <= cfg_data;
			end
			case (state_q)
				tccw_pkg::ST_INIT, tccw_pkg::ST_BLANK, tccw_pkg::ST_CLEAR: begin
					cnt_q <= (cnt_q == LAST_CELL) ? '0 : cnt_q + AW'(1);
				end
				tccw_pkg::ST_COPY: begin
					if (cnt_q != COPY_END) cnt_q <= cnt_q + AW'(1);
				end
				tccw_pkg::ST_EXEC: begin
					cnt_q <= '0;
					row_q <= row_d;
					col_q <= col_d;
					scr_q <= (mode_q == tccw_pkg::MODE_PUT) && scroll;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
			if (ld_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= tccw_pkg::mode_t'(s_tdata[1:0]);
			char_q <= s_tdata[9:2];
			srow_q <= s_tdata[14:10];
			scol_q <= s_tdata[21:15];
		end
		if (ld_out) begin
			m_tdata_q <= {3'b0, out_at, out_ch, out_scr, out_col, out_row};
		end
	end

endmodule

[design/tccw_checker.sv]
module tccw_checker #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [tccw_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam logic [4:0] LAST_ROW = 5'(ROWS - 1);
	localparam logic [7:0] COLS_L   = 8'(COLUMNS);
	localparam logic [5:0] ROWS_L   = 6'(ROWS);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, m_tdata[4:0]} < ROWS_L) && ({1'b0, m_tdata[11:5]} < COLS_L))
		else $error("cursor out of range");

	a_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12] |-> (m_tdata[4:0] == LAST_ROW) && (m_tdata[11:5] == 7'd0)
			&& (m_tdata[28:13] == 16'd0))
		else $error("scroll beat with wrong cursor or cell data");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

endmodule

bind text_console_cell_writer_core tccw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS(ROWS)
) u_tccw_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
